>>> src/htw_pkg.sv
// Shared constants and types for the hierarchical timer wheel.
`default_nettype none
package htw_pkg;
  localparam int ROOT_BITS    = 8;
  localparam int LEVEL_BITS   = 6;
  localparam int LEVELS       = 5;
  localparam int POOL_ENTRIES = 64;

  localparam int ROOT_SIZE  = 1 << ROOT_BITS;
  localparam int LEVEL_SIZE = 1 << LEVEL_BITS;
  localparam int LEVEL_MASK = LEVEL_SIZE - 1;
  localparam int SLOT_COUNT = ROOT_SIZE + (LEVELS - 1) * LEVEL_SIZE;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int PTR_W      = 7;
  localparam int IDX_W      = $clog2(POOL_ENTRIES);
  localparam int LV_W       = (LEVELS > 2) ? $clog2(LEVELS - 1) : 1;

  localparam logic [PTR_W-1:0] NIL = 7'd127;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_EXP  = 1'b1;
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  typedef struct packed {
    logic [31:0]       expiry;
    logic [SLOT_W-1:0] slot;
  } file_res_t;
endpackage
`default_nettype wire

>>> src/htw_file_calc.sv
// Clamp of an expiry and choice of its wheel slot.
`default_nettype none
module htw_file_calc import htw_pkg::*; (
  input  wire logic [31:0] expiry,
  input  wire logic [31:0] tick,
  input  wire logic        past_mode,
  output file_res_t        res
);
  logic [31:0] gap;
  logic [31:0] cdist;
  logic [31:0] cexp;
  logic        found;

  always_comb begin
    gap   = expiry - tick;
    cexp  = expiry;
    cdist = gap;
    if (past_mode) begin
      if (gap[31]) begin
        cexp  = tick;
        cdist = 32'd0;
      end
    end else if (gap[31] || gap == 32'd0) begin
      cexp  = tick + 32'd1;
      cdist = 32'd1;
    end
    res.expiry = cexp;
    res.slot   = SLOT_W'(cexp[ROOT_BITS-1:0]);
    found      = ({32'd0, cdist} < (64'd1 << ROOT_BITS));
    for (int j = 1; j < LEVELS; j++) begin
      if (!found && (j == LEVELS - 1 ||
                     {32'd0, cdist} < (64'd1 << (ROOT_BITS + j * LEVEL_BITS)))) begin
        found    = 1'b1;
        res.slot = SLOT_W'(ROOT_SIZE + (j - 1) * LEVEL_SIZE) +
                   SLOT_W'(({32'd0, cexp} >> (ROOT_BITS + (j - 1) * LEVEL_BITS)) &
                           64'(LEVEL_MASK));
      end
    end
  end
endmodule
`default_nettype wire

>>> src/hierarchical_timer_wheel_unit.sv
// Top level: sequencer, slot and entry memories of the timer wheel.
//
//  port group | dir | handshake          | transaction
//  in_*       | in  | in_valid/in_stall  | add timer or advance one tick
//  out_*      | out | out_valid/out_stall| add status or expired timer
//  cfg_*      | in  | cfg_valid/cfg_ready| past_mode write
//
// After reset a sweep over all SLOT_COUNT (512) slots empties the slot memory; no
// transaction is taken meanwhile.
// Add: accept, free-list pop, slot read, slot update, result; the result waits
// for the output, and a full pool goes straight from accept to result. Tick: on
// root wrap the due level slots are cascaded and refiled, then root timers expire.
// One item is in work at a time; the output register holds a result under stall.
`default_nettype none
module hierarchical_timer_wheel_unit import htw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [31:0] in_expires,
  input  wire logic [31:0] in_timer_id,
  input  wire logic [31:0] in_tag,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic             out_status,
  output logic [31:0]      out_id,
  output logic [31:0]      out_tag,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_past_mode
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ADD_POP, S_FILE1, S_FILE2, S_EMIT_ADD,
    S_CAS_START, S_CAS_HEAD, S_CAS_ENT, S_CAS_RD,
    S_ROOT_START, S_ROOT_HEAD, S_ROOT_ENT, S_ROOT_RD
  } state_t;

  state_t                 state_r;
  logic [SLOT_W-1:0]      sweep_r;
  logic [PTR_W-1:0]       ent_r;
  logic [PTR_W-1:0]       nx_r;
  logic [31:0]            exp_r;
  logic [LV_W-1:0]        lvl_r;
  logic [IDX_W:0]         guard_r;
  logic [31:0]            tick_r;
  logic [ROOT_BITS-1:0]   root_r;
  logic [LEVEL_BITS-1:0]  lvl_idx_r [LEVELS-1];
  logic [PTR_W-1:0]       free_head_r;
  logic                   mode_r;
  logic                   ret_cas_r;
  logic [SLOT_W-1:0]      slot_s_r;
  logic [31:0]            id_r;
  logic [31:0]            tag_r;
  logic                   out_valid_r;
  logic                   out_kind_r;
  logic                   out_status_r;
  logic [31:0]            out_id_r;
  logic [31:0]            out_tag_r;
  logic                   out_last_r;

  // memories
  logic [2*PTR_W-1:0] slot_mem [SLOT_COUNT];
  logic [31:0]        exp_mem  [POOL_ENTRIES];
  logic [63:0]        it_mem   [POOL_ENTRIES];
  logic [PTR_W-1:0]   next_mem [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0] nv_r;

  logic [2*PTR_W-1:0] slot_rd_r;
  logic [31:0]        exp_rd_r;
  logic [63:0]        it_rd_r;
  logic [PTR_W-1:0]   next_rd_r;
  logic               next_rdv_r;
  logic [IDX_W-1:0]   next_ra_r;

  logic               slot_re, slot_we;
  logic [SLOT_W-1:0]  slot_raddr, slot_waddr;
  logic [2*PTR_W-1:0] slot_wdata;
  logic               next_re, next_we;
  logic [IDX_W-1:0]   next_raddr, next_waddr;
  logic [PTR_W-1:0]   next_wdata;
  logic               ent_re, exp_we, it_we;
  logic [IDX_W-1:0]   ent_raddr;

  logic [PTR_W-1:0]   next_val;
  logic [PTR_W-1:0]   rd_head, rd_tail;
  logic               out_free;
  logic               out_load;
  logic               in_acc;
  logic               ent_ok;
  logic               root_done;
  logic [LEVEL_BITS-1:0] lvl_idx_inc;
  logic [SLOT_W-1:0]  cas_slot;
  file_res_t          fres;

  htw_file_calc u_calc (
    .expiry    (exp_r),
    .tick      (tick_r),
    .past_mode (mode_r),
    .res       (fres)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_status = out_status_r;
  assign out_id     = out_id_r;
  assign out_tag    = out_tag_r;
  assign out_last   = out_last_r;
  assign out_free   = !out_valid_r || !out_stall;
  assign out_load   = out_free && (state_r == S_EMIT_ADD || state_r == S_ROOT_RD);

  // unwritten next pointers read as the reset free chain
  assign next_val = next_rdv_r ? next_rd_r :
                    ((32'(next_ra_r) + 32'd1 < 32'(POOL_ENTRIES)) ?
                     PTR_W'(32'(next_ra_r) + 32'd1) : NIL);
  assign rd_head  = slot_rd_r[2*PTR_W-1:PTR_W];
  assign rd_tail  = slot_rd_r[PTR_W-1:0];
  assign ent_ok   = (32'(ent_r) < 32'(POOL_ENTRIES));
  assign lvl_idx_inc = lvl_idx_r[lvl_r] + LEVEL_BITS'(1);
  assign cas_slot = SLOT_W'(ROOT_SIZE) + (SLOT_W'(lvl_r) << LEVEL_BITS) +
                    SLOT_W'(lvl_idx_r[lvl_r]);
  assign root_done = !ent_ok || guard_r[IDX_W];

  always_comb begin
    slot_re = 1'b0; slot_raddr = fres.slot;
    slot_we = 1'b0; slot_waddr = slot_s_r; slot_wdata = {NIL, NIL};
    next_re = 1'b0; next_raddr = ent_r[IDX_W-1:0];
    next_we = 1'b0; next_waddr = ent_r[IDX_W-1:0]; next_wdata = NIL;
    ent_re  = 1'b0; ent_raddr = ent_r[IDX_W-1:0];
    exp_we  = 1'b0; it_we = 1'b0;
    case (state_r)
      S_CLEAR: begin
        slot_we = 1'b1; slot_waddr = sweep_r;
      end
      S_IDLE: begin
        next_raddr = free_head_r[IDX_W-1:0];
        next_re    = in_acc && in_func == FUNC_ADD && (32'(free_head_r) < 32'(POOL_ENTRIES));
      end
      S_ADD_POP: it_we = 1'b1;
      S_FILE1: begin
        exp_we = 1'b1; next_we = 1'b1; slot_re = 1'b1;
      end
      S_FILE2: begin
        if (rd_head == NIL || 32'(rd_head) >= 32'(POOL_ENTRIES)) begin
          slot_wdata = {ent_r, ent_r};
        end else begin
          slot_wdata = {rd_head, ent_r};
          if (32'(rd_tail) < 32'(POOL_ENTRIES)) begin
            next_we = 1'b1; next_waddr = rd_tail[IDX_W-1:0]; next_wdata = ent_r;
          end
        end
        slot_we = 1'b1;
      end
      S_CAS_START: begin
        slot_re = 1'b1; slot_raddr = cas_slot;
        slot_we = 1'b1; slot_waddr = cas_slot;
      end
      S_CAS_ENT: begin
        next_re = ent_ok && !guard_r[IDX_W];
        ent_re  = next_re;
      end
      S_ROOT_START: begin
        slot_re = 1'b1; slot_raddr = SLOT_W'(root_r);
        slot_we = 1'b1; slot_waddr = SLOT_W'(root_r);
      end
      S_ROOT_ENT: begin
        next_re = !root_done;
        ent_re  = next_re;
      end
      S_ROOT_RD: begin
        next_we = out_free; next_wdata = free_head_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_rd_r <= slot_mem[slot_raddr];
    if (exp_we) exp_mem[ent_r[IDX_W-1:0]] <= fres.expiry;
    if (it_we) it_mem[ent_r[IDX_W-1:0]] <= {id_r, tag_r};
    if (ent_re) begin
      exp_rd_r <= exp_mem[ent_raddr];
      it_rd_r  <= it_mem[ent_raddr];
    end
    if (next_we) next_mem[next_waddr] <= next_wdata;
    if (next_re) begin
      next_rd_r  <= next_mem[next_raddr];
      next_rdv_r <= nv_r[next_raddr];
      next_ra_r  <= next_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= '0;
    end else if (next_we) begin
      nv_r[next_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sweep_r     <= '0;
      tick_r      <= '0;
      root_r      <= '0;
      free_head_r <= '0;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LEVELS - 1; i++) lvl_idx_r[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) mode_r <= cfg_past_mode;
      if (!out_load && out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          sweep_r <= sweep_r + SLOT_W'(1);
          if (32'(sweep_r) == SLOT_COUNT - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            exp_r <= in_expires;
            id_r  <= in_timer_id;
            tag_r <= in_tag;
            ent_r <= free_head_r;
            if (in_func == FUNC_ADD) begin
              ret_cas_r <= 1'b0;
              if (32'(free_head_r) < 32'(POOL_ENTRIES)) state_r <= S_ADD_POP;
              else state_r <= S_EMIT_ADD;
            end else if (root_r == '0) begin
              lvl_r   <= '0;
              state_r <= S_CAS_START;
            end else begin
              state_r <= S_ROOT_START;
            end
          end
        end
        S_ADD_POP: begin
          free_head_r <= next_val;
          state_r     <= S_FILE1;
        end
        S_FILE1: begin
          slot_s_r <= fres.slot;
          state_r  <= S_FILE2;
        end
        S_FILE2: begin
          if (ret_cas_r) begin
            ent_r   <= nx_r;
            guard_r <= guard_r + (IDX_W+1)'(1);
            state_r <= S_CAS_ENT;
          end else begin
            state_r <= S_EMIT_ADD;
          end
        end
        S_EMIT_ADD: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= KIND_ADD;
            out_status_r <= (32'(ent_r) < 32'(POOL_ENTRIES)) ? STAT_OK : STAT_FULL;
            out_id_r     <= id_r;
            out_tag_r    <= tag_r;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_CAS_START: state_r <= S_CAS_HEAD;
        S_CAS_HEAD: begin
          ent_r            <= rd_head;
          guard_r          <= '0;
          ret_cas_r        <= 1'b1;
          lvl_idx_r[lvl_r] <= lvl_idx_inc;
          state_r          <= S_CAS_ENT;
        end
        S_CAS_ENT: begin
          if (ent_ok && !guard_r[IDX_W]) begin
            state_r <= S_CAS_RD;
          end else if (lvl_idx_r[lvl_r] == LEVEL_BITS'(1) &&
                       32'(lvl_r) + 1 < LEVELS - 1) begin
            // this level wrapped too: cascade the next one up
            lvl_r   <= lvl_r + LV_W'(1);
            state_r <= S_CAS_START;
          end else begin
            state_r <= S_ROOT_START;
          end
        end
        S_CAS_RD: begin
          nx_r    <= next_val;
          exp_r   <= exp_rd_r;
          state_r <= S_FILE1;
        end
        S_ROOT_START: state_r <= S_ROOT_HEAD;
        S_ROOT_HEAD: begin
          ent_r   <= rd_head;
          guard_r <= '0;
          state_r <= S_ROOT_ENT;
        end
        S_ROOT_ENT: begin
          if (!root_done) begin
            state_r <= S_ROOT_RD;
          end else begin
            tick_r  <= tick_r + 32'd1;
            root_r  <= root_r + ROOT_BITS'(1);
            state_r <= S_IDLE;
          end
        end
        S_ROOT_RD: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= KIND_EXP;
            out_status_r <= STAT_OK;
            out_id_r     <= it_rd_r[63:32];
            out_tag_r    <= it_rd_r[31:0];
            out_last_r   <= (32'(next_val) >= 32'(POOL_ENTRIES)) ||
                            (32'(guard_r) == POOL_ENTRIES - 1);
            free_head_r  <= ent_r;
            ent_r        <= next_val;
            guard_r      <= guard_r + (IDX_W+1)'(1);
            state_r      <= S_ROOT_ENT;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_file_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILE1) |-> (32'(ent_r) < 32'(POOL_ENTRIES)))
    else $error("filing an invalid entry");

  a_free_head_code: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(free_head_r) < 32'(POOL_ENTRIES)) || (free_head_r == NIL))
    else $error("free list head corrupt");

  a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT_ENT && root_done) |=> (tick_r == $past(tick_r) + 32'd1))
    else $error("tick did not advance");
endmodule
`default_nettype wire

>>> tb/tb.sv
// Testbench for hierarchical_timer_wheel_unit: random and directed stimulus with a scoreboard.
`timescale 1ns / 100ps
module tb;
  import htw_pkg::*;

  typedef struct {
    logic        kind;
    logic        status;
    logic [31:0] id;
    logic [31:0] tag;
    logic        last;
  } wheel_result_t;

  class wheel_scoreboard;
    bit                mode;
    bit [31:0]         tick;
    bit [ROOT_BITS-1:0] root;
    bit [LEVEL_BITS-1:0] lvl[LEVELS-1];
    bit [31:0]         e_exp[POOL_ENTRIES];
    bit [31:0]         e_id[POOL_ENTRIES];
    bit [31:0]         e_tag[POOL_ENTRIES];
    bit [PTR_W-1:0]    e_next[POOL_ENTRIES];
    bit [PTR_W-1:0]    s_head[SLOT_COUNT];
    bit [PTR_W-1:0]    s_tail[SLOT_COUNT];
    bit [PTR_W-1:0]    free_head;
    wheel_result_t     pending_q[$];
    int                errors;

    function new();
      mode = 0;
      tick = 0;
      root = 0;
      errors = 0;
      foreach (lvl[i]) lvl[i] = 0;
      for (int i = 0; i < POOL_ENTRIES; i++)
        e_next[i] = (i + 1 < POOL_ENTRIES) ? PTR_W'(i + 1) : NIL;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        s_head[i] = NIL;
        s_tail[i] = NIL;
      end
      free_head = 0;
    endfunction

    function void file_timer(int e);
      bit [31:0] x;
      bit [31:0] d;
      int s;
      int k;
      x = e_exp[e];
      d = x - tick;
      if (mode) begin
        if (d[31]) begin
          x = tick;
          d = 0;
        end
      end else if (d[31] || d == 0) begin
        x = tick + 1;
        d = 1;
      end
      e_exp[e] = x;
      if (d < ROOT_SIZE) begin
        s = x[ROOT_BITS-1:0];
      end else begin
        k = 1;
        while (k < LEVELS - 1 && 64'(d) >= (64'd1 << (ROOT_BITS + k * LEVEL_BITS))) k++;
        s = ROOT_SIZE + (k - 1) * LEVEL_SIZE +
            ((x >> (ROOT_BITS + (k - 1) * LEVEL_BITS)) & LEVEL_MASK);
      end
      e_next[e] = NIL;
      if (s_head[s] == NIL) s_head[s] = PTR_W'(e);
      else e_next[s_tail[s]] = PTR_W'(e);
      s_tail[s] = PTR_W'(e);
    endfunction

    function void cascade_level(int n);
      int s;
      bit [PTR_W-1:0] e;
      bit [PTR_W-1:0] nx;
      s = ROOT_SIZE + (n - 1) * LEVEL_SIZE + lvl[n-1];
      e = s_head[s];
      s_head[s] = NIL;
      s_tail[s] = NIL;
      while (e != NIL) begin
        nx = e_next[e];
        file_timer(e);
        e = nx;
      end
      lvl[n-1] = LEVEL_BITS'(lvl[n-1] + 1);
    endfunction

    // Works out the results of one accepted transaction.
    function void note_input(logic func, logic [31:0] expires, logic [31:0] id,
                             logic [31:0] tag);
      wheel_result_t r;
      bit [PTR_W-1:0] e;
      bit [PTR_W-1:0] nx;
      int n;
      int s;
      if (func == FUNC_ADD) begin
        r.kind = KIND_ADD;
        r.id = id;
        r.tag = tag;
        r.last = 1;
        if (free_head == NIL) begin
          r.status = STAT_FULL;
        end else begin
          e = free_head;
          free_head = e_next[e];
          e_exp[e] = expires;
          e_id[e] = id;
          e_tag[e] = tag;
          file_timer(e);
          r.status = STAT_OK;
        end
        pending_q.push_back(r);
        return;
      end
      if (root == 0) begin
        n = 1;
        forever begin
          cascade_level(n);
          if (lvl[n-1] != 1) break;
          n++;
          if (n >= LEVELS) break;
        end
      end
      s = root;
      e = s_head[s];
      s_head[s] = NIL;
      s_tail[s] = NIL;
      while (e != NIL) begin
        nx = e_next[e];
        r.kind = KIND_EXP;
        r.status = STAT_OK;
        r.id = e_id[e];
        r.tag = e_tag[e];
        r.last = (nx == NIL);
        pending_q.push_back(r);
        e_next[e] = free_head;
        free_head = e;
        e = nx;
      end
      tick = tick + 1;
      root = ROOT_BITS'(root + 1);
    endfunction

    function void check_result(wheel_result_t got);
      wheel_result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result id=%h tag=%h", got.id, got.tag);
        return;
      end
      want = pending_q.pop_front();
      if (got.kind !== want.kind || got.status !== want.status || got.id !== want.id ||
          got.tag !== want.tag || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp k=%b s=%b id=%h tag=%h l=%b got k=%b s=%b id=%h tag=%h l=%b",
                   want.kind, want.status, want.id, want.tag, want.last,
                   got.kind, got.status, got.id, got.tag, got.last);
      end
    endfunction
  endclass

  localparam int SETTLE = 1500;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [31:0] in_expires;
  logic [31:0] in_timer_id;
  logic [31:0] in_tag;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic        out_status;
  logic [31:0] out_id;
  logic [31:0] out_tag;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_past_mode;

  wheel_scoreboard sb;
  int idle_cycles;
  int results_seen;
  int hold_left;
  bit hold_done;
  int stall_pct;

  hierarchical_timer_wheel_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_expires(in_expires), .in_timer_id(in_timer_id), .in_tag(in_tag),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_status(out_status), .out_id(out_id), .out_tag(out_tag), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_past_mode(cfg_past_mode)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Receiver: stall pattern changes at random times; one long hold-off after 100 results.
  always @(posedge clk) begin
    wheel_result_t r;
    if (out_valid && !out_stall) begin
      r.kind = out_kind;
      r.status = out_status;
      r.id = out_id;
      r.tag = out_tag;
      r.last = out_last;
      sb.check_result(r);
      results_seen++;
    end
    if (!hold_done && results_seen >= 100) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_pct <= $urandom_range(0, 2) * 35;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL hierarchical_timer_wheel_unit");
      $finish;
    end
  end

  // Offers one transaction and returns at the edge where it is taken.
  task automatic send_item(logic func, logic [31:0] expires, logic [31:0] id,
                           logic [31:0] tag);
    in_valid <= 1'b1;
    in_func <= func;
    in_expires <= expires;
    in_timer_id <= id;
    in_tag <= tag;
    do @(posedge clk); while (in_stall);
    sb.note_input(func, expires, id, tag);
  endtask

  task automatic add_at(logic [31:0] expires);
    send_item(FUNC_ADD, expires, $urandom, $urandom);
  endtask

  task automatic tick_once();
    send_item(FUNC_TICK, $urandom, $urandom, $urandom);
  endtask

  task automatic go_idle(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(bit v);
    cfg_valid <= 1'b1;
    cfg_past_mode <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.mode = v;
  endtask

  function automatic logic [31:0] pick_expiry();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return sb.tick + $urandom_range(0, 40);
    if (r < 65) return sb.tick + $urandom_range(41, 300);
    if (r < 78) return sb.tick - $urandom_range(0, 5);
    if (r < 88) return sb.tick + $urandom_range(256, 20000);
    return $urandom;
  endfunction

  task automatic random_burst(int count, int tick_pct);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && count > 0) begin
        if ($urandom_range(0, 99) < tick_pct) tick_once();
        else add_at(pick_expiry());
        burst--;
        count--;
      end
      if ($urandom_range(0, 3) != 0) go_idle($urandom_range(1, 8));
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_ADD;
    in_expires = '0;
    in_timer_id = '0;
    in_tag = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_past_mode = 1'b0;
    idle_cycles = 0;
    results_seen = 0;
    hold_left = 0;
    hold_done = 0;
    stall_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(1'b0);

    // Directed: clamping, every level, extreme field values.
    tick_once();
    send_item(FUNC_ADD, 32'h0, 32'h0, 32'h0);
    send_item(FUNC_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    add_at(32'd1);
    add_at(32'd2);
    add_at(32'd256);
    add_at(32'd300);
    add_at(32'd1 << 14);
    add_at(32'd1 << 20);
    add_at(32'd1 << 26);
    add_at(32'h7fff_ffff);
    repeat (4) tick_once();
    drain();

    write_mode(1'b1);
    add_at(sb.tick);
    add_at(sb.tick - 1);
    add_at(sb.tick + 1);
    send_item(FUNC_ADD, 32'h8000_0000, 32'h5555_5555, 32'haaaa_aaaa);
    repeat (3) tick_once();
    random_burst(100, 80);
    drain();

    // Flood the pool while the receiver may be holding off, then walk out the timers.
    write_mode(1'b0);
    repeat (66) add_at(sb.tick + $urandom_range(1, 200));
    random_burst(30, 55);
    repeat (140) tick_once();
    drain();

    write_mode(1'b1);
    random_burst(25, 80);
    drain();

    if (sb.errors == 0) $display("PASS hierarchical_timer_wheel_unit");
    else $display("FAIL hierarchical_timer_wheel_unit");
    $finish;
  end
endmodule

>>> hierarchical_timer_wheel_unit.f
src/htw_pkg.sv
src/htw_file_calc.sv
src/hierarchical_timer_wheel_unit.sv
tb/tb.sv
